@@ rtl/core/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the framer checkers
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define LFX_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// assertion on the block clock and reset
`define LFX_ASSERT(label, prop, msg) \
	`LFX_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

@@ rtl/core/lfx_pkg.sv @@
// ------------------------------------------------------------------------
// lfx_pkg
// types and constants shared by the length-prefixed xor framer
// ------------------------------------------------------------------------
`default_nettype none

package lfx_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0]  HEAD_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  HEAD_SECOND_RST = 8'h55;
	localparam logic [7:0]  TAIL_BYTE_RST   = 8'h0D;
	localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_LEN        = 2'd1,
		ERR_IDLE_DATA  = 2'd2,
		ERR_BUSY_START = 2'd3
	} err_e_t;

	typedef enum logic [0:0] {
		REQ_START = 1'b0,
		REQ_DATA  = 1'b1
	} req_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_FIRST  = 8'd0,
		REG_HEAD_SECOND = 8'd1,
		REG_TAIL_BYTE   = 8'd2,
		REG_MAX_LENGTH  = 8'd3
	} reg_idx_e_t;

	typedef struct packed {
		logic [7:0]  head_first;
		logic [7:0]  head_second;
		logic [7:0]  tail_byte;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
		err_e_t     error;
	} result_t;

	typedef struct packed {
		logic [RES_IDX_W-1:0]            last_idx;
		result_t [MAX_RESULTS-1:0]       res;
	} burst_t;

endpackage

`default_nettype wire

@@ rtl/core/lfx_cfg_regs.sv @@
// ------------------------------------------------------------------------
// lfx_cfg_regs
// configuration register file: header, tail and length limit
// ------------------------------------------------------------------------
`default_nettype none

module lfx_cfg_regs import lfx_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_first  <= HEAD_FIRST_RST;
			cfg_q.head_second <= HEAD_SECOND_RST;
			cfg_q.tail_byte   <= TAIL_BYTE_RST;
			cfg_q.max_length  <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_HEAD_FIRST:  cfg_q.head_first  <= wr_data[7:0];
				REG_HEAD_SECOND: cfg_q.head_second <= wr_data[7:0];
				REG_TAIL_BYTE:   cfg_q.tail_byte   <= wr_data[7:0];
				REG_MAX_LENGTH:  cfg_q.max_length  <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/lfx_frame_ctrl.sv @@
// ------------------------------------------------------------------------
// lfx_frame_ctrl
// frame state, xor accumulation and per-item result burst generation
// ------------------------------------------------------------------------
`default_nettype none

module lfx_frame_ctrl import lfx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        req_type,
	input  wire logic [15:0] frame_length,
	input  wire logic [7:0]  data_byte,
	input  cfg_t             cfg,
	output burst_t           burst
);

	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  running_xor_q;

	logic        in_frame_d;
	logic [15:0] bytes_left_d;
	logic [7:0]  running_xor_d;
	logic [15:0] left_dec;
	logic [7:0]  xor_next;

	function automatic result_t mk_res(logic [7:0] b, logic fe, logic rl, err_e_t e);
		result_t r;
		r.out_byte  = b;
		r.frame_end = fe;
		r.run_last  = rl;
		r.error     = e;
		return r;
	endfunction

	assign left_dec = bytes_left_q - 16'd1;
	assign xor_next = running_xor_q ^ data_byte;

	always_comb begin
		in_frame_d    = in_frame_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		burst.last_idx = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			burst.res[i] = mk_res(8'd0, 1'b0, 1'b0, ERR_NONE);
		end
		if (req_type == REQ_START) begin
			if (in_frame_q) begin
				burst.res[0] = mk_res(8'd0, 1'b0, 1'b1, ERR_BUSY_START);
			end else if (frame_length == 16'd0 || frame_length > cfg.max_length) begin
				burst.res[0] = mk_res(8'd0, 1'b0, 1'b1, ERR_LEN);
			end else begin
				in_frame_d     = 1'b1;
				bytes_left_d   = frame_length;
				running_xor_d  = 8'd0;
				burst.last_idx = RES_IDX_W'(3);
				burst.res[0]   = mk_res(cfg.head_first, 1'b0, 1'b0, ERR_NONE);
				burst.res[1]   = mk_res(cfg.head_second, 1'b0, 1'b0, ERR_NONE);
				burst.res[2]   = mk_res(frame_length[15:8], 1'b0, 1'b0, ERR_NONE);
				burst.res[3]   = mk_res(frame_length[7:0], 1'b0, 1'b1, ERR_NONE);
			end
		end else begin
			if (!in_frame_q) begin
				burst.res[0] = mk_res(8'd0, 1'b0, 1'b1, ERR_IDLE_DATA);
			end else begin
				running_xor_d = xor_next;
				bytes_left_d  = left_dec;
				if (left_dec != 16'd0) begin
					burst.res[0] = mk_res(data_byte, 1'b0, 1'b1, ERR_NONE);
				end else begin
					in_frame_d     = 1'b0;
					burst.last_idx = RES_IDX_W'(2);
					burst.res[0]   = mk_res(data_byte, 1'b0, 1'b0, ERR_NONE);
					burst.res[1]   = mk_res(xor_next, 1'b0, 1'b0, ERR_NONE);
					burst.res[2]   = mk_res(cfg.tail_byte, 1'b1, 1'b1, ERR_NONE);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			bytes_left_q  <= 16'd0;
			running_xor_q <= 8'd0;
		end else if (accept) begin
			in_frame_q    <= in_frame_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lfx_out_burst.sv @@
// ------------------------------------------------------------------------
// lfx_out_burst
// result register: holds one item's burst and sends it a byte per transfer
// ------------------------------------------------------------------------
`default_nettype none

module lfx_out_burst import lfx_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  burst_t    load_burst,
	output logic      room,
	output logic      out_valid,
	input  wire logic out_stall,
	output result_t   out_res
);

	logic                   valid_q;
	logic [RES_IDX_W-1:0]   idx_q;
	logic [RES_IDX_W-1:0]   last_q;
	result_t [MAX_RESULTS-1:0] res_q;

	logic take;
	logic done;

	assign take      = valid_q && !out_stall;
	assign done      = take && (idx_q == last_q);
	assign room      = !valid_q || done;
	assign out_valid = valid_q;
	assign out_res   = res_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			last_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
			last_q  <= load_burst.last_idx;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_burst.res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/length_prefixed_xor_framer.sv @@
// ------------------------------------------------------------------------
// length_prefixed_xor_framer
// timing: first result of an item is valid in the cycle after its transfer
// throughput: one single-result item per cycle while out_stall is low; a start
//   emits four bytes and a closing data byte three, one per output transfer
// the result register sets the rate: a new item enters as its last byte leaves
// reset: frame state, burst register and config registers return to defaults
// ------------------------------------------------------------------------
`default_nettype none

module length_prefixed_xor_framer import lfx_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_type,
	input  wire logic [15:0]           frame_length,
	input  wire logic [7:0]            data_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic                       frame_end,
	output logic                       run_last,
	output logic [1:0]                 error,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	burst_t  burst;
	result_t out_res;
	logic    room;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign accept    = in_valid && room;

	lfx_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lfx_frame_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.frame_length (frame_length),
		.data_byte    (data_byte),
		.cfg          (cfg),
		.burst        (burst)
	);

	lfx_out_burst u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.load_burst (burst),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res)
	);

	assign out_byte  = out_res.out_byte;
	assign frame_end = out_res.frame_end;
	assign run_last  = out_res.run_last;
	assign error     = out_res.error;

endmodule

`default_nettype wire

@@ rtl/core/lfx_checker.sv @@
// ------------------------------------------------------------------------
// lfx_checker
// port-level checks on the framer result stream
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfx_checker import lfx_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [7:0]            out_byte,
	input wire logic                  frame_end,
	input wire logic                  run_last,
	input wire logic [1:0]            error
);

	`LFX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last), "stalled result changed")
	`LFX_ASSERT(a_err_shape, out_valid && error != ERR_NONE |-> out_byte == 8'd0 && run_last && !frame_end, "error result malformed")
	`LFX_ASSERT(a_end_is_last, out_valid && frame_end |-> run_last && error == ERR_NONE, "frame end not last of burst")
	`LFX_ASSERT(a_burst_blocks, out_valid && !run_last |-> in_stall, "input taken during unfinished burst")

endmodule

bind length_prefixed_xor_framer lfx_checker u_lfx_checker (.*);

`default_nettype wire
